// File: rtl/stepper_ramp_pulse_generator_core_defines.svh
// Assertion macros shared by the stepper ramp pulse generator RTL.
// Every macro expects signals named clk and rst_n in the enclosing scope.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRPG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srpg_pkg.sv
// Shared types, constants and helper functions of the stepper ramp pulse generator.
// It has no dependencies; every RTL module refers to it by scoped names.
package srpg_pkg;

    localparam int DELAY_W = 12;
    localparam int STEPS_W = 7;
    localparam int MOTOR_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [DELAY_W-1:0] DELAY_MAX  = 12'd4095;
    localparam logic [DELAY_W-1:0] DECEL_STEP = 12'd20;
    localparam logic [DELAY_W-1:0] ACCEL_FAST = 12'd10;
    localparam logic [DELAY_W-1:0] ACCEL_SLOW = 12'd5;

    localparam logic [DELAY_W-1:0] RST_START_DELAY = 12'd425;
    localparam logic [DELAY_W-1:0] RST_STAGE_ONE   = 12'd350;
    localparam logic [DELAY_W-1:0] RST_STAGE_TWO   = 12'd150;
    localparam logic [DELAY_W-1:0] RST_MIN_DELAY   = 12'd140;
    localparam logic [STEPS_W-1:0] RST_Q_ACCEL     = 7'd40;
    localparam logic [STEPS_W-1:0] RST_Q_DECEL     = 7'd10;
    localparam logic [STEPS_W-1:0] RST_H_ACCEL     = 7'd85;
    localparam logic [STEPS_W-1:0] RST_H_DECEL     = 7'd15;

    localparam logic       FUNC_MOVE     = 1'b0;
    localparam logic       FUNC_TICK     = 1'b1;
    localparam logic [1:0] TURNS_QUARTER = 2'd1;
    localparam logic [1:0] TURNS_HALF    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_DELAY = 3'd0,
        REG_STAGE_ONE   = 3'd1,
        REG_STAGE_TWO   = 3'd2,
        REG_MIN_DELAY   = 3'd3,
        REG_Q_ACCEL     = 3'd4,
        REG_Q_DECEL     = 3'd5,
        REG_H_ACCEL     = 3'd6,
        REG_H_DECEL     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] start_delay;
        logic [DELAY_W-1:0] stage_one_threshold;
        logic [DELAY_W-1:0] stage_two_threshold;
        logic [DELAY_W-1:0] min_delay;
        logic [STEPS_W-1:0] quarter_accel_steps;
        logic [STEPS_W-1:0] quarter_decel_steps;
        logic [STEPS_W-1:0] half_accel_steps;
        logic [STEPS_W-1:0] half_decel_steps;
    } cfg_t;

    typedef struct packed {
        logic               direction;
        logic [1:0]         turns;
        logic [MOTOR_W-1:0] motor;
    } cmd_t;

    typedef struct packed {
        logic               rejected;
        logic               done_res;
        logic               busy_res;
        logic               dir_level;
        logic [MOTOR_W-1:0] motor_select;
        logic               step_level;
    } result_t;

    function automatic logic [DELAY_W-1:0] delay_at_least_one(input logic [DELAY_W-1:0] d);
        return (d == '0) ? DELAY_W'(1) : d;
    endfunction

    function automatic logic [STEPS_W-1:0] steps_at_least_one(input logic [STEPS_W-1:0] s);
        return (s == '0) ? STEPS_W'(1) : s;
    endfunction

    function automatic logic [DELAY_W-1:0] drop_floor(input logic [DELAY_W-1:0] d,
                                                      input logic [DELAY_W-1:0] by);
        return (d > by) ? (d - by) : DELAY_W'(1);
    endfunction

endpackage

// File: rtl/stepper_ramp_pulse_generator_core.sv
// Top level of the stepper ramp pulse generator: input and result registers around
// the move state machine. Depends on srpg_pkg, srpg_cfg_regs, srpg_ramp and the defines.
`include "stepper_ramp_pulse_generator_core_defines.svh"

// Usage
// The slave stream carries one beat per command or microsecond tick: s_tuser selects
// a move command (0) or a tick (1), and s_tdata holds motor, turns and direction.
// Every accepted beat yields exactly one result beat on the master stream, carrying
// the step level, selected motor, direction level, busy, done and rejected flags.
// A result beat passes through one input register and one result register, with the
// move state updated as the beat leaves the input register. Throughput is one beat
// per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; s_tready then falls until m_tready returns.
// Reset empties both pipeline registers, clears the move state, and loads the
// configuration registers with their default ramp values. Configuration writes
// through cfg_we, cfg_index and cfg_data take effect on the next clock edge and
// should be made only while no beat is in flight and no move is active.
module stepper_ramp_pulse_generator_core #(
    parameter int NUM_MOTORS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srpg_pkg::DELAY_W-1:0]    cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] motor, [4:3] turns, [5] direction, [7:6] zero
    input  logic [7:0]                      s_tdata,
    // [0] func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] step_level, [3:1] motor_select, [4] dir_level, [5] busy_res,
    // [6] done_res, [7] rejected
    output logic [7:0]                      m_tdata
);

    logic                   in_valid_reg, in_valid_next;
    logic                   in_func_reg;
    srpg_pkg::cmd_t         in_cmd_reg;
    logic                   out_valid_reg, out_valid_next;
    srpg_pkg::result_t      out_res_reg;
    srpg_pkg::result_t      res;
    srpg_pkg::cfg_t         cfg;
    logic                   advance;
    logic                   fire;
    logic                   take_in;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    assign in_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    srpg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srpg_ramp #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_ramp (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .func   (in_func_reg),
        .cmd    (in_cmd_reg),
        .cfg    (cfg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_func_reg <= s_tuser;
            in_cmd_reg  <= srpg_pkg::cmd_t'(s_tdata[5:0]);
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    `SRPG_ASSERT_SAME(a_done_ends_move, out_valid_reg && out_res_reg.done_res,
        !out_res_reg.busy_res && !out_res_reg.rejected,
        "Finishing beat reports a move still busy or a refusal")
    `SRPG_ASSERT_NEXT(a_stall_holds_result, out_valid_reg && !m_tready,
        out_valid_reg && $stable(out_res_reg),
        "Stalled result beat changed or vanished")
    `SRPG_ASSERT_SAME(a_no_accept_when_full, in_valid_reg && out_valid_reg && !m_tready,
        !s_tready, "Input taken while both pipeline registers are full")

endmodule

// File: rtl/srpg_cfg_regs.sv
// Configuration register file of the stepper ramp pulse generator.
// Depends on srpg_pkg for the register index codes and the cfg_t bundle.
module srpg_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srpg_pkg::DELAY_W-1:0]        cfg_data,
    output srpg_pkg::cfg_t                      cfg
);

    srpg_pkg::cfg_t cfg_reg;
    srpg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (srpg_pkg::cfg_idx_t'(cfg_index))
                srpg_pkg::REG_START_DELAY: cfg_next.start_delay         = cfg_data;
                srpg_pkg::REG_STAGE_ONE:   cfg_next.stage_one_threshold = cfg_data;
                srpg_pkg::REG_STAGE_TWO:   cfg_next.stage_two_threshold = cfg_data;
                srpg_pkg::REG_MIN_DELAY:   cfg_next.min_delay           = cfg_data;
                srpg_pkg::REG_Q_ACCEL:
                    cfg_next.quarter_accel_steps = cfg_data[srpg_pkg::STEPS_W-1:0];
                srpg_pkg::REG_Q_DECEL:
                    cfg_next.quarter_decel_steps = cfg_data[srpg_pkg::STEPS_W-1:0];
                srpg_pkg::REG_H_ACCEL:
                    cfg_next.half_accel_steps = cfg_data[srpg_pkg::STEPS_W-1:0];
                srpg_pkg::REG_H_DECEL:
                    cfg_next.half_decel_steps = cfg_data[srpg_pkg::STEPS_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay         <= srpg_pkg::RST_START_DELAY;
            cfg_reg.stage_one_threshold <= srpg_pkg::RST_STAGE_ONE;
            cfg_reg.stage_two_threshold <= srpg_pkg::RST_STAGE_TWO;
            cfg_reg.min_delay           <= srpg_pkg::RST_MIN_DELAY;
            cfg_reg.quarter_accel_steps <= srpg_pkg::RST_Q_ACCEL;
            cfg_reg.quarter_decel_steps <= srpg_pkg::RST_Q_DECEL;
            cfg_reg.half_accel_steps    <= srpg_pkg::RST_H_ACCEL;
            cfg_reg.half_decel_steps    <= srpg_pkg::RST_H_DECEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/srpg_ramp.sv
// Move state and step timing of the stepper ramp pulse generator.
// Depends on srpg_pkg and on the assertion macros in the defines header.
`include "stepper_ramp_pulse_generator_core_defines.svh"

module srpg_ramp #(
    parameter int NUM_MOTORS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                func,
    input  srpg_pkg::cmd_t      cmd,
    input  srpg_pkg::cfg_t      cfg,
    output srpg_pkg::result_t   result
);

    logic                               active_reg, active_next;
    logic                               half_mode_reg, half_mode_next;
    logic                               decel_phase_reg, decel_phase_next;
    logic [srpg_pkg::MOTOR_W-1:0]       motor_index_reg, motor_index_next;
    logic                               dir_held_reg, dir_held_next;
    logic [srpg_pkg::STEPS_W-1:0]       steps_left_reg, steps_left_next;
    logic [srpg_pkg::DELAY_W-1:0]       cur_delay_reg, cur_delay_next;
    logic [srpg_pkg::DELAY_W-1:0]       tick_left_reg, tick_left_next;
    logic                               pulse_high_reg, pulse_high_next;

    logic                               bad_cmd;
    logic [srpg_pkg::DELAY_W-1:0]       tick_dec;
    logic [srpg_pkg::STEPS_W-1:0]       steps_dec;
    logic [srpg_pkg::DELAY_W:0]         decel_sum;
    logic [srpg_pkg::DELAY_W-1:0]       new_delay;
    logic                               done;
    logic                               rej;

    // Motor numbers are compared one bit wider so that a count of eight still fits.
    assign bad_cmd = active_reg
                   || ({1'b0, cmd.motor} >= (srpg_pkg::MOTOR_W + 1)'(NUM_MOTORS))
                   || ((cmd.turns != srpg_pkg::TURNS_QUARTER)
                       && (cmd.turns != srpg_pkg::TURNS_HALF));

    assign tick_dec  = (tick_left_reg != '0) ? (tick_left_reg - 1'b1) : '0;
    assign steps_dec = (steps_left_reg != '0) ? (steps_left_reg - 1'b1) : '0;
    assign decel_sum = {1'b0, cur_delay_reg} + {1'b0, srpg_pkg::DECEL_STEP};

    // Delay applied at the end of each completed step.
    always_comb
    begin
        if (decel_phase_reg)
            new_delay = decel_sum[srpg_pkg::DELAY_W] ? srpg_pkg::DELAY_MAX
                                                    : decel_sum[srpg_pkg::DELAY_W-1:0];
        else if (cur_delay_reg > cfg.stage_one_threshold)
            new_delay = srpg_pkg::drop_floor(cur_delay_reg, srpg_pkg::ACCEL_FAST);
        else if (!half_mode_reg)
            new_delay = srpg_pkg::drop_floor(cur_delay_reg, srpg_pkg::ACCEL_SLOW);
        else if (cur_delay_reg > cfg.stage_two_threshold)
            new_delay = srpg_pkg::drop_floor(cur_delay_reg, srpg_pkg::ACCEL_SLOW);
        else if (cur_delay_reg > cfg.min_delay)
            new_delay = cur_delay_reg - 1'b1;
        else
            new_delay = cur_delay_reg;
    end

    always_comb
    begin
        active_next      = active_reg;
        half_mode_next   = half_mode_reg;
        decel_phase_next = decel_phase_reg;
        motor_index_next = motor_index_reg;
        dir_held_next    = dir_held_reg;
        steps_left_next  = steps_left_reg;
        cur_delay_next   = cur_delay_reg;
        tick_left_next   = tick_left_reg;
        pulse_high_next  = pulse_high_reg;
        done             = 1'b0;
        rej              = 1'b0;

        if (func == srpg_pkg::FUNC_MOVE)
        begin
            if (bad_cmd)
            begin
                rej = 1'b1;
            end
            else
            begin
                active_next      = 1'b1;
                half_mode_next   = (cmd.turns == srpg_pkg::TURNS_HALF);
                decel_phase_next = 1'b0;
                motor_index_next = cmd.motor;
                dir_held_next    = cmd.direction;
                steps_left_next  = srpg_pkg::steps_at_least_one(
                    (cmd.turns == srpg_pkg::TURNS_HALF) ? cfg.half_accel_steps
                                                        : cfg.quarter_accel_steps);
                cur_delay_next   = cfg.start_delay;
                tick_left_next   = srpg_pkg::delay_at_least_one(cfg.start_delay);
                pulse_high_next  = 1'b1;
            end
        end
        else if (active_reg)
        begin
            tick_left_next = tick_dec;
            if (tick_dec == '0)
            begin
                if (pulse_high_reg)
                begin
                    pulse_high_next = 1'b0;
                    tick_left_next  = srpg_pkg::delay_at_least_one(cur_delay_reg);
                end
                else
                begin
                    cur_delay_next  = new_delay;
                    steps_left_next = steps_dec;
                    if (steps_dec == '0)
                    begin
                        if (!decel_phase_reg)
                        begin
                            decel_phase_next = 1'b1;
                            steps_left_next  = srpg_pkg::steps_at_least_one(
                                half_mode_reg ? cfg.half_decel_steps : cfg.quarter_decel_steps);
                        end
                        else
                        begin
                            active_next = 1'b0;
                            done        = 1'b1;
                        end
                    end
                    if (done)
                    begin
                        pulse_high_next = 1'b0;
                        tick_left_next  = '0;
                    end
                    else
                    begin
                        pulse_high_next = 1'b1;
                        tick_left_next  = srpg_pkg::delay_at_least_one(new_delay);
                    end
                end
            end
        end
    end

    // A tick reports the level it was held at; a command reports the level after it.
    always_comb
    begin
        result.step_level   = (func == srpg_pkg::FUNC_MOVE) ? pulse_high_next : pulse_high_reg;
        result.motor_select = motor_index_next;
        result.dir_level    = dir_held_next;
        result.busy_res     = active_next;
        result.done_res     = done;
        result.rejected     = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            half_mode_reg   <= 1'b0;
            decel_phase_reg <= 1'b0;
            motor_index_reg <= '0;
            dir_held_reg    <= 1'b0;
            steps_left_reg  <= '0;
            cur_delay_reg   <= '0;
            tick_left_reg   <= '0;
            pulse_high_reg  <= 1'b0;
        end
        else if (fire)
        begin
            active_reg      <= active_next;
            half_mode_reg   <= half_mode_next;
            decel_phase_reg <= decel_phase_next;
            motor_index_reg <= motor_index_next;
            dir_held_reg    <= dir_held_next;
            steps_left_reg  <= steps_left_next;
            cur_delay_reg   <= cur_delay_next;
            tick_left_reg   <= tick_left_next;
            pulse_high_reg  <= pulse_high_next;
        end
    end

    `SRPG_ASSERT_SAME(a_idle_pulse_low, !active_reg, !pulse_high_reg,
        "Step output high while no move is active")
    `SRPG_ASSERT_SAME(a_active_ticks_left, active_reg, tick_left_reg != '0,
        "Active move has an empty half-step timer")
    `SRPG_ASSERT_NEXT(a_reject_keeps_state, fire && rej,
        $stable(active_reg) && $stable(motor_index_reg) && $stable(cur_delay_reg),
        "Refused command altered the move state")

endmodule

// File: dv/stepper_ramp_pulse_generator_core_tb.sv
// Self-checking testbench for the stepper ramp pulse generator core.
// Drives commands and ticks on the slave stream and checks every result beat against its own
// model of the ramp. Depends on srpg_pkg and the RTL top level.
`timescale 1ns / 1ps

module stepper_ramp_pulse_generator_core_tb;

    localparam int MOTORS       = 6;
    localparam int RANDOM_BEATS = 700;
    localparam int DRAIN_TICKS  = 16;
    localparam int CYCLE_LIMIT  = 200_000;

    typedef struct packed {
        logic           func;
        srpg_pkg::cmd_t cmd;
    } beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;

    // Ramp settings as the block should hold them.
    logic [11:0] cfg_start = srpg_pkg::RST_START_DELAY;
    logic [11:0] cfg_th1   = srpg_pkg::RST_STAGE_ONE;
    logic [11:0] cfg_th2   = srpg_pkg::RST_STAGE_TWO;
    logic [11:0] cfg_min   = srpg_pkg::RST_MIN_DELAY;
    logic [6:0]  cfg_qa    = srpg_pkg::RST_Q_ACCEL;
    logic [6:0]  cfg_qd    = srpg_pkg::RST_Q_DECEL;
    logic [6:0]  cfg_ha    = srpg_pkg::RST_H_ACCEL;
    logic [6:0]  cfg_hd    = srpg_pkg::RST_H_DECEL;

    // Move state as the block should hold it.
    logic        ramp_busy  = 1'b0;
    logic        ramp_half  = 1'b0;
    logic        ramp_decel = 1'b0;
    logic [2:0]  ramp_motor = '0;
    logic        ramp_dir   = 1'b0;
    logic [6:0]  steps_togo = '0;
    logic [11:0] delay_now  = '0;
    logic [11:0] ticks_togo = '0;
    logic        step_high  = 1'b0;

    beat_t             beat_backlog[$];
    srpg_pkg::result_t due_results[$];
    int      beats_queued = 0;
    int      beats_taken  = 0;
    int      fail_count   = 0;
    int      cycle_count  = 0;
    logic    beat_taken   = 1'b0;
    int      burst_left   = 0;
    int      gap_left     = 0;
    int      rx_mode      = 0;
    int      rx_hold      = 0;

    stepper_ramp_pulse_generator_core #(
        .NUM_MOTORS(MOTORS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the expected move state by one accepted beat and returns its result.
    task automatic step_ramp(input logic func, input srpg_pkg::cmd_t c,
                             output srpg_pkg::result_t r);
        int next_d;
        r = '0;
        if (func == srpg_pkg::FUNC_MOVE)
        begin
            if (ramp_busy || int'(c.motor) >= MOTORS ||
                (c.turns != srpg_pkg::TURNS_QUARTER && c.turns != srpg_pkg::TURNS_HALF))
            begin
                r.rejected = 1'b1;
            end
            else
            begin
                ramp_busy  = 1'b1;
                ramp_half  = (c.turns == srpg_pkg::TURNS_HALF);
                ramp_decel = 1'b0;
                ramp_motor = c.motor;
                ramp_dir   = c.direction;
                steps_togo = ramp_half ? cfg_ha : cfg_qa;
                if (steps_togo == 0)
                    steps_togo = 7'd1;
                delay_now  = cfg_start;
                ticks_togo = (delay_now == 0) ? 12'd1 : delay_now;
                step_high  = 1'b1;
            end
            r.step_level = step_high;
        end
        else
        begin
            r.step_level = step_high;
            if (ramp_busy)
            begin
                if (ticks_togo != 0)
                    ticks_togo--;
                if (ticks_togo == 0)
                begin
                    if (step_high)
                    begin
                        step_high  = 1'b0;
                        ticks_togo = (delay_now == 0) ? 12'd1 : delay_now;
                    end
                    else
                    begin
                        // The delay moves once per completed step, before the phase check.
                        if (ramp_decel)
                        begin
                            next_d    = int'(delay_now) + int'(srpg_pkg::DECEL_STEP);
                            delay_now = (next_d > int'(srpg_pkg::DELAY_MAX)) ?
                                        srpg_pkg::DELAY_MAX : 12'(next_d);
                        end
                        else if (delay_now > cfg_th1)
                            delay_now = (delay_now > srpg_pkg::ACCEL_FAST) ?
                                        delay_now - srpg_pkg::ACCEL_FAST : 12'd1;
                        else if (!ramp_half || delay_now > cfg_th2)
                            delay_now = (delay_now > srpg_pkg::ACCEL_SLOW) ?
                                        delay_now - srpg_pkg::ACCEL_SLOW : 12'd1;
                        else if (delay_now > cfg_min)
                            delay_now = delay_now - 12'd1;

                        if (steps_togo != 0)
                            steps_togo--;
                        if (steps_togo == 0)
                        begin
                            if (!ramp_decel)
                            begin
                                ramp_decel = 1'b1;
                                steps_togo = ramp_half ? cfg_hd : cfg_qd;
                                if (steps_togo == 0)
                                    steps_togo = 7'd1;
                            end
                            else
                            begin
                                ramp_busy  = 1'b0;
                                r.done_res = 1'b1;
                            end
                        end
                        step_high = ramp_busy;
                        if (ramp_busy)
                            ticks_togo = (delay_now == 0) ? 12'd1 : delay_now;
                        else
                            ticks_togo = '0;
                    end
                end
            end
        end
        r.motor_select = ramp_motor;
        r.dir_level    = ramp_dir;
        r.busy_res     = ramp_busy;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void queue_move(int motor, int turns, int dir);
        beat_t b;
        b.func          = srpg_pkg::FUNC_MOVE;
        b.cmd.motor     = 3'(motor);
        b.cmd.turns     = 2'(turns);
        b.cmd.direction = 1'(dir);
        beat_backlog.push_back(b);
        beats_queued++;
    endfunction

    function automatic void queue_any_cmd();
        queue_move($urandom_range(7), $urandom_range(3), $urandom_range(1));
    endfunction

    // Ticks carry random data bits, which the block ignores.
    function automatic void queue_ticks(int n);
        beat_t b;
        repeat (n)
        begin
            b.func = srpg_pkg::FUNC_TICK;
            b.cmd  = srpg_pkg::cmd_t'(6'($urandom));
            beat_backlog.push_back(b);
            beats_queued++;
        end
    endfunction

    // Step count with junk in the bits above the 7-bit register.
    function automatic logic [11:0] rand_steps(int hi);
        logic [11:0] v;
        v      = 12'($urandom);
        v[6:0] = 7'($urandom_range(hi));
        return v;
    endfunction

    task automatic settle();
        do
            @(negedge clk);
        while (beats_queued != beats_taken || due_results.size() != 0);
    endtask

    task automatic finish_moves();
        settle();
        while (ramp_busy)
        begin
            queue_ticks(DRAIN_TICKS);
            settle();
        end
    endtask

    task automatic write_reg(srpg_pkg::cfg_idx_t idx, logic [11:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            srpg_pkg::REG_START_DELAY: cfg_start = val;
            srpg_pkg::REG_STAGE_ONE:   cfg_th1   = val;
            srpg_pkg::REG_STAGE_TWO:   cfg_th2   = val;
            srpg_pkg::REG_MIN_DELAY:   cfg_min   = val;
            srpg_pkg::REG_Q_ACCEL:     cfg_qa    = val[6:0];
            srpg_pkg::REG_Q_DECEL:     cfg_qd    = val[6:0];
            srpg_pkg::REG_H_ACCEL:     cfg_ha    = val[6:0];
            default:                   cfg_hd    = val[6:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_ramp(logic [11:0] start, logic [11:0] th1, logic [11:0] th2,
                            logic [11:0] dmin, logic [11:0] qa, logic [11:0] qd,
                            logic [11:0] ha, logic [11:0] hd);
        write_reg(srpg_pkg::REG_START_DELAY, start);
        write_reg(srpg_pkg::REG_STAGE_ONE, th1);
        write_reg(srpg_pkg::REG_STAGE_TWO, th2);
        write_reg(srpg_pkg::REG_MIN_DELAY, dmin);
        write_reg(srpg_pkg::REG_Q_ACCEL, qa);
        write_reg(srpg_pkg::REG_Q_DECEL, qd);
        write_reg(srpg_pkg::REG_H_ACCEL, ha);
        write_reg(srpg_pkg::REG_H_DECEL, hd);
    endtask

    // Sender: bursts of random length separated by random gaps, some of them empty.
    always @(negedge clk)
    begin : drive
        beat_t b;
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (beat_backlog.size() != 0)
            begin
                b = beat_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= b.func;
                s_tdata  <= {2'b00, b.cmd};
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(48, 1);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(7, 1);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: switches between always ready, sparse stalls, a fixed rhythm and coin flips.
    always @(negedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode = $urandom_range(3);
            rx_hold = $urandom_range(160, 16);
        end
        rx_hold--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(3) != 0);
            2:       m_tready <= ((rx_hold % 5) >= 2);
            default: m_tready <= 1'($urandom_range(1));
        endcase
    end

    always @(posedge clk)
    begin : watch
        srpg_pkg::result_t want;
        srpg_pkg::result_t got;
        if (!rst_n)
            beat_taken <= 1'b0;
        else
        begin
            beat_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                step_ramp(s_tuser, srpg_pkg::cmd_t'(s_tdata[5:0]), want);
                due_results.push_back(want);
                beats_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got = srpg_pkg::result_t'(m_tdata);
                if (due_results.size() == 0)
                begin
                    $error("result beat %h arrived with nothing expected", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("step_level", want.step_level, got.step_level);
                    check_field("motor_select", want.motor_select, got.motor_select);
                    check_field("dir_level", want.dir_level, got.dir_level);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("rejected", want.rejected, got.rejected);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stepper_ramp_pulse_generator_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int random_beats;
        int mark;
        random_beats = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle ticks and commands refused for a bad motor or turns code.
        queue_ticks(2);
        queue_move(6, srpg_pkg::TURNS_QUARTER, 0);
        queue_move(7, srpg_pkg::TURNS_HALF, 1);
        queue_move(0, 0, 0);
        queue_move(1, 3, 1);
        finish_moves();

        // Reset accelerating counts and thresholds, run at the shortest delay so that
        // the moves stay short; a command during a move is refused.
        write_reg(srpg_pkg::REG_START_DELAY, 12'd1);
        write_reg(srpg_pkg::REG_Q_DECEL, 12'd1);
        write_reg(srpg_pkg::REG_H_DECEL, 12'd1);
        queue_move(0, srpg_pkg::TURNS_QUARTER, 1);
        queue_move(2, srpg_pkg::TURNS_HALF, 0);
        finish_moves();
        queue_move(2, srpg_pkg::TURNS_HALF, 0);
        finish_moves();

        // Short ramp that passes through every acceleration stage and the plateau.
        set_ramp(30, 25, 12, 6, 3, 2, 12, 2);
        queue_move(5, srpg_pkg::TURNS_HALF, 0);
        queue_ticks(3);
        queue_move(3, srpg_pkg::TURNS_QUARTER, 1);
        finish_moves();

        // Zero delay and zero step counts behave as one.
        set_ramp(0, 0, 0, 0, 0, 0, 0, 0);
        queue_move(1, srpg_pkg::TURNS_QUARTER, 1);
        finish_moves();
        queue_move(3, srpg_pkg::TURNS_HALF, 0);
        finish_moves();

        // Longest acceleration at the delay floor.
        set_ramp(1, 1, 1, 1, 127, 2, 127, 2);
        queue_move(0, srpg_pkg::TURNS_QUARTER, 0);
        finish_moves();

        // Largest deceleration counts are only loaded; a full move at them is far too long.
        set_ramp(2, 3, 2, 1, 1, 127, 1, 127);
        queue_ticks(3);
        queue_move(7, 3, 1);
        finish_moves();

        while (random_beats < RANDOM_BEATS)
        begin
            set_ramp($urandom_range(24), $urandom_range(24), $urandom_range(16),
                     $urandom_range(12), rand_steps(5), rand_steps(3), rand_steps(5),
                     rand_steps(3));
            mark = beats_queued;
            repeat ($urandom_range(3, 1))
            begin
                if ($urandom_range(7) == 0)
                    queue_any_cmd();
                queue_move($urandom_range(MOTORS - 1),
                           ($urandom_range(1) == 0) ? srpg_pkg::TURNS_QUARTER
                                                    : srpg_pkg::TURNS_HALF,
                           $urandom_range(1));
                repeat ($urandom_range(60, 1))
                begin
                    if ($urandom_range(39) == 0)
                        queue_any_cmd();
                    else
                        queue_ticks(1);
                end
            end
            finish_moves();
            random_beats += beats_queued - mark;
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("stepper_ramp_pulse_generator_core_tb: done, clean");
        else
            $display("stepper_ramp_pulse_generator_core_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/srpg_pkg.sv
rtl/srpg_cfg_regs.sv
rtl/srpg_ramp.sv
rtl/stepper_ramp_pulse_generator_core.sv
dv/stepper_ramp_pulse_generator_core_tb.sv
